// ----- hw/rtl/iet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iet_pkg: shared types and constants of the input event translator
// Event codes, report kinds, the key usage table and the sequencer states.
// ----------------------------------------------------------------------------
package iet_pkg;

  localparam logic [1:0] MODE_KEYBOARD = 2'd0;
  localparam logic [1:0] MODE_MOUSE    = 2'd1;
  localparam logic [1:0] MODE_TABLET   = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [2:0] REG_DEVICE_MODE = 3'd0;
  localparam logic [2:0] REG_ABS_X_MIN   = 3'd1;
  localparam logic [2:0] REG_ABS_X_MAX   = 3'd2;
  localparam logic [2:0] REG_ABS_Y_MIN   = 3'd3;
  localparam logic [2:0] REG_ABS_Y_MAX   = 3'd4;

  localparam logic [15:0] EV_SYN = 16'd0;
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;
  localparam logic [15:0] EV_ABS = 16'd3;

  localparam logic [15:0] BTN_LEFT   = 16'h110;
  localparam logic [15:0] BTN_RIGHT  = 16'h111;
  localparam logic [15:0] BTN_MIDDLE = 16'h112;
  localparam logic [15:0] BTN_SIDE   = 16'h113;
  localparam logic [15:0] BTN_EXTRA  = 16'h114;
  localparam logic [15:0] REL_WHEEL  = 16'd8;

  localparam logic [1:0] KIND_KEY_DOWN = 2'd0;
  localparam logic [1:0] KIND_KEY_UP   = 2'd1;
  localparam logic [1:0] KIND_REL      = 2'd2;
  localparam logic [1:0] KIND_ABS      = 2'd3;

  localparam int KEY_TABLE_SIZE = 128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_KEYRD,
    ST_CLEAR
  } iet_state_t;

  function automatic logic [7:0] key_usage(input logic [6:0] code);
    logic [7:0] u;
    begin
      unique case (code)
        7'd30: u = 8'd4;    7'd48: u = 8'd5;    7'd46: u = 8'd6;
        7'd32: u = 8'd7;    7'd18: u = 8'd8;    7'd33: u = 8'd9;
        7'd34: u = 8'd10;   7'd35: u = 8'd11;   7'd23: u = 8'd12;
        7'd36: u = 8'd13;   7'd37: u = 8'd14;   7'd38: u = 8'd15;
        7'd50: u = 8'd16;   7'd49: u = 8'd17;   7'd24: u = 8'd18;
        7'd25: u = 8'd19;   7'd16: u = 8'd20;   7'd19: u = 8'd21;
        7'd31: u = 8'd22;   7'd20: u = 8'd23;   7'd22: u = 8'd24;
        7'd47: u = 8'd25;   7'd17: u = 8'd26;   7'd45: u = 8'd27;
        7'd21: u = 8'd28;   7'd44: u = 8'd29;
        7'd2: u = 8'd30;    7'd3: u = 8'd31;    7'd4: u = 8'd32;
        7'd5: u = 8'd33;    7'd6: u = 8'd34;    7'd7: u = 8'd35;
        7'd8: u = 8'd36;    7'd9: u = 8'd37;    7'd10: u = 8'd38;
        7'd59: u = 8'd58;   7'd60: u = 8'd59;   7'd61: u = 8'd60;
        7'd62: u = 8'd61;   7'd63: u = 8'd62;   7'd64: u = 8'd63;
        7'd65: u = 8'd64;   7'd66: u = 8'd65;   7'd67: u = 8'd66;
        7'd68: u = 8'd67;
        7'd11: u = 8'd39;   7'd28: u = 8'd40;   7'd1: u = 8'd41;
        7'd14: u = 8'd42;   7'd15: u = 8'd43;   7'd57: u = 8'd44;
        7'd12: u = 8'd45;   7'd13: u = 8'd46;   7'd26: u = 8'd47;
        7'd27: u = 8'd48;   7'd43: u = 8'd49;   7'd86: u = 8'd50;
        7'd39: u = 8'd51;   7'd40: u = 8'd52;   7'd41: u = 8'd53;
        7'd51: u = 8'd54;   7'd52: u = 8'd55;   7'd53: u = 8'd56;
        7'd58: u = 8'd57;   7'd87: u = 8'd68;   7'd88: u = 8'd69;
        7'd99: u = 8'd70;   7'd70: u = 8'd71;   7'd119: u = 8'd72;
        7'd110: u = 8'd73;  7'd102: u = 8'd74;  7'd104: u = 8'd75;
        7'd111: u = 8'd76;  7'd107: u = 8'd77;  7'd109: u = 8'd78;
        7'd106: u = 8'd79;  7'd105: u = 8'd80;  7'd108: u = 8'd81;
        7'd103: u = 8'd82;  7'd69: u = 8'd83;
        7'd29: u = 8'd224;  7'd42: u = 8'd225;  7'd56: u = 8'd226;
        7'd125: u = 8'd227; 7'd97: u = 8'd228;  7'd54: u = 8'd229;
        7'd100: u = 8'd230; 7'd126: u = 8'd231;
        default: u = 8'd0;
      endcase
      key_usage = u;
    end
  endfunction

endpackage

// ----- hw/rtl/iet_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iet_ram: generic simple dual-port RAM
// One write and one read port at shared timing, registered read data.
// ----------------------------------------------------------------------------
module iet_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/iet_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iet_divider: serial restoring divider
// Divides a 49-bit unsigned dividend by a 33-bit divisor, one quotient bit
// per cycle; only the low 17 quotient bits are kept.
// ----------------------------------------------------------------------------
module iet_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);

  logic [48:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [34:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[48]} - {2'b00, div_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = 6'd49;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[34]) begin
        rem_nxt = trial[33:0];
        quo_nxt = {quo_r[47:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[32:0], quo_r[48]};
        quo_nxt = {quo_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = busy_r && (cnt_r == 6'd1);
  assign quotient = quo_nxt[16:0];

endmodule

// ----- hw/rtl/input_event_translator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_translator: event to HID report translator
// Turns evdev-style events into key and pointer reports.
// ----------------------------------------------------------------------------
// Usage: an event word enters on in_valid/in_stall. Each event gives zero or
// one report word on out_valid/out_stall, held in an output register.
// in_stall is high while an event is being processed and while a report still
// waits in the output register, so one event is handled at a time.
// Timing: an event is decoded in the cycle after it is accepted, and the next
// event is accepted only after the block is back in its idle state. A mapped
// key event passes through a key RAM read state before its report word is
// registered. A sync report word is registered from the decode state. The next
// accept also waits until a report word has left the output register.
// A tablet axis value strictly inside the range runs the serial divider, one
// quotient bit per cycle, and the next event waits until the divider is done.
// Reset: rst_n is synchronous. After reset a pass over all 256 entries clears
// the key state RAM; no event is taken during it. Configuration writes are
// taken at any time and go to their registers directly.
// A stalled report holds its value; the block takes no event until it leaves.
// Configuration must only change while the block is idle.
// ----------------------------------------------------------------------------
module input_event_translator #(
  parameter int ABS_SCALE_MAX = 32767
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_event_type,
  input  logic [15:0] in_event_code,
  input  logic signed [31:0] in_event_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_report_kind,
  output logic [7:0]  out_hid_usage,
  output logic [4:0]  out_button_mask,
  output logic signed [31:0] out_delta_x,
  output logic signed [31:0] out_delta_y,
  output logic signed [31:0] out_wheel_delta,
  output logic [14:0] out_position_x,
  output logic [14:0] out_position_y
);

  localparam logic [16:0] SCALE = 17'(ABS_SCALE_MAX);

  iet_pkg::iet_state_t state_r, state_nxt;

  logic [1:0] mode_r;
  logic signed [31:0] xmin_r, xmax_r, ymin_r, ymax_r;

  logic [15:0] typ_r, typ_nxt, code_r, code_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [7:0] clr_r, clr_nxt;
  logic [7:0] hid_r, hid_nxt;

  logic [4:0] btn_r, btn_nxt;
  logic signed [31:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt, acc_w_r, acc_w_nxt;
  logic [14:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic dirty_r, dirty_nxt;

  logic ov_r, ov_nxt;
  logic [1:0] o_kind_r, o_kind_nxt;
  logic [7:0] o_hid_r, o_hid_nxt;
  logic [4:0] o_btn_r, o_btn_nxt;
  logic signed [31:0] o_dx_r, o_dx_nxt, o_dy_r, o_dy_nxt, o_w_r, o_w_nxt;
  logic [14:0] o_px_r, o_px_nxt, o_py_r, o_py_nxt;

  // Key RAM
  logic       ram_we;
  logic [7:0] ram_waddr, ram_raddr;
  logic       ram_wdata, ram_rdata;

  iet_ram #(.WIDTH(1), .DEPTH(256)) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Divider
  logic        div_start, div_done;
  logic [48:0] div_dividend;
  logic [32:0] div_divisor;
  logic [16:0] div_q;

  iet_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  // Shared 33-bit adder for accumulation, axis offsets and the mouse Y negation.
  logic signed [32:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      sat33 = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      sat33 = 32'sh80000000;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  logic sel_y;
  logic signed [31:0] amin, amax;
  logic [4:0] bmask;
  logic [14:0] cur_pos;
  logic [14:0] new_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= iet_pkg::MODE_KEYBOARD;
      xmin_r <= '0;
      xmax_r <= 32'sd1;
      ymin_r <= '0;
      ymax_r <= 32'sd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iet_pkg::REG_DEVICE_MODE: mode_r <= cfg_wdata[1:0];
        iet_pkg::REG_ABS_X_MIN:   xmin_r <= cfg_wdata;
        iet_pkg::REG_ABS_X_MAX:   xmax_r <= cfg_wdata;
        iet_pkg::REG_ABS_Y_MIN:   ymin_r <= cfg_wdata;
        iet_pkg::REG_ABS_Y_MAX:   ymax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    typ_nxt    = typ_r;
    code_nxt   = code_r;
    val_nxt    = val_r;
    clr_nxt    = clr_r;
    hid_nxt    = hid_r;
    btn_nxt    = btn_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    acc_w_nxt  = acc_w_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    dirty_nxt  = dirty_r;
    ov_nxt     = ov_r && out_stall;
    o_kind_nxt = o_kind_r;
    o_hid_nxt  = o_hid_r;
    o_btn_nxt  = o_btn_r;
    o_dx_nxt   = o_dx_r;
    o_dy_nxt   = o_dy_r;
    o_w_nxt    = o_w_r;
    o_px_nxt   = o_px_r;
    o_py_nxt   = o_py_r;
    ram_we     = 1'b0;
    ram_waddr  = hid_r;
    ram_wdata  = 1'b0;
    ram_raddr  = hid_r;
    div_start  = 1'b0;
    sel_y      = code_r[0];
    amin       = sel_y ? ymin_r : xmin_r;
    amax       = sel_y ? ymax_r : xmax_r;
    cur_pos    = sel_y ? pos_y_r : pos_x_r;
    new_pos    = cur_pos;
    add_a      = '0;
    add_b      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    bmask = '0;
    unique case (code_r)
      iet_pkg::BTN_LEFT:   bmask = 5'b00001;
      iet_pkg::BTN_MIDDLE: bmask = 5'b00010;
      iet_pkg::BTN_RIGHT:  bmask = 5'b00100;
      iet_pkg::BTN_SIDE:   bmask = 5'b01000;
      iet_pkg::BTN_EXTRA:  bmask = 5'b10000;
      default:             bmask = 5'b00000;
    endcase

    unique case (state_r)
      iet_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 8'd1;
        if (clr_r == 8'hff) begin
          state_nxt = iet_pkg::ST_IDLE;
        end
      end
      iet_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          typ_nxt   = in_event_type;
          code_nxt  = in_event_code;
          val_nxt   = in_event_value;
          state_nxt = iet_pkg::ST_EXEC;
        end
      end
      iet_pkg::ST_EXEC: begin
        state_nxt = iet_pkg::ST_IDLE;
        if (mode_r == iet_pkg::MODE_KEYBOARD) begin
          hid_nxt = 8'd0;
          if (typ_r == iet_pkg::EV_KEY && (val_r == 32'sd0 || val_r == 32'sd1)
              && code_r < 16'(iet_pkg::KEY_TABLE_SIZE)) begin
            hid_nxt = iet_pkg::key_usage(code_r[6:0]);
          end
          if (hid_nxt != 8'd0) begin
            ram_raddr = hid_nxt;
            state_nxt = iet_pkg::ST_KEYRD;
          end
        end else if (mode_r != iet_pkg::MODE_UNUSED) begin
          if (typ_r == iet_pkg::EV_SYN && code_r == 16'd0) begin
            if (dirty_r) begin
              ov_nxt    = 1'b1;
              o_hid_nxt = 8'd0;
              o_btn_nxt = btn_r;
              o_w_nxt   = acc_w_r;
              if (mode_r == iet_pkg::MODE_MOUSE) begin
                o_kind_nxt = iet_pkg::KIND_REL;
                o_dx_nxt   = acc_x_r;
                add_b      = -{acc_y_r[31], acc_y_r};
                o_dy_nxt   = sat33(add_s);
                o_px_nxt   = '0;
                o_py_nxt   = '0;
              end else begin
                o_kind_nxt = iet_pkg::KIND_ABS;
                o_dx_nxt   = '0;
                o_dy_nxt   = '0;
                o_px_nxt   = pos_x_r;
                o_py_nxt   = pos_y_r;
              end
              acc_x_nxt = '0;
              acc_y_nxt = '0;
              acc_w_nxt = '0;
              dirty_nxt = 1'b0;
            end
          end else if (typ_r == iet_pkg::EV_KEY && (val_r == 32'sd0 || val_r == 32'sd1)) begin
            btn_nxt = val_r[0] ? (btn_r | bmask) : (btn_r & ~bmask);
            if (btn_nxt != btn_r) begin
              dirty_nxt = 1'b1;
            end
          end else if (typ_r == iet_pkg::EV_REL) begin
            add_b = {val_r[31], val_r};
            if (code_r == iet_pkg::REL_WHEEL) begin
              add_a     = {acc_w_r[31], acc_w_r};
              acc_w_nxt = sat33(add_s);
              dirty_nxt = 1'b1;
            end else if (mode_r == iet_pkg::MODE_MOUSE && code_r <= 16'd1) begin
              add_a = sel_y ? {acc_y_r[31], acc_y_r} : {acc_x_r[31], acc_x_r};
              if (sel_y) begin
                acc_y_nxt = sat33(add_s);
              end else begin
                acc_x_nxt = sat33(add_s);
              end
              dirty_nxt = 1'b1;
            end
          end else if (typ_r == iet_pkg::EV_ABS && mode_r == iet_pkg::MODE_TABLET
                       && code_r <= 16'd1) begin
            if (val_r <= amin) begin
              new_pos = '0;
            end else if (val_r >= amax) begin
              new_pos = SCALE[14:0];
            end else begin
              // Offset first; the span is formed when the divider starts.
              add_a     = {val_r[31], val_r};
              add_b     = -{amin[31], amin};
              val_nxt   = add_s[31:0];
              state_nxt = iet_pkg::ST_DIV;
              div_start = 1'b1;
              div_dividend = {16'd0, add_s} * {32'd0, SCALE};
              div_divisor  = 33'({amax[31], amax} - {amin[31], amin});
            end
            if (state_nxt != iet_pkg::ST_DIV) begin
              if (new_pos != cur_pos) begin
                dirty_nxt = 1'b1;
              end
              if (sel_y) begin
                pos_y_nxt = new_pos;
              end else begin
                pos_x_nxt = new_pos;
              end
            end
          end
        end
      end
      iet_pkg::ST_DIV: begin
        if (div_done) begin
          new_pos = div_q[14:0];
          if (new_pos != cur_pos) begin
            dirty_nxt = 1'b1;
          end
          if (sel_y) begin
            pos_y_nxt = new_pos;
          end else begin
            pos_x_nxt = new_pos;
          end
          state_nxt = iet_pkg::ST_IDLE;
        end
      end
      iet_pkg::ST_KEYRD: begin
        if (ram_rdata != val_r[0]) begin
          ram_we     = 1'b1;
          ram_waddr  = hid_r;
          ram_wdata  = val_r[0];
          ov_nxt     = 1'b1;
          o_kind_nxt = val_r[0] ? iet_pkg::KIND_KEY_DOWN : iet_pkg::KIND_KEY_UP;
          o_hid_nxt  = hid_r;
          o_btn_nxt  = '0;
          o_dx_nxt   = '0;
          o_dy_nxt   = '0;
          o_w_nxt    = '0;
          o_px_nxt   = '0;
          o_py_nxt   = '0;
        end
        state_nxt = iet_pkg::ST_IDLE;
      end
      default: state_nxt = iet_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iet_pkg::ST_CLEAR;
      clr_r   <= '0;
      btn_r   <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_w_r <= '0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      dirty_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      btn_r   <= btn_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      acc_w_r <= acc_w_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      dirty_r <= dirty_nxt;
      ov_r    <= ov_nxt;
    end
    typ_r    <= typ_nxt;
    code_r   <= code_nxt;
    val_r    <= val_nxt;
    hid_r    <= hid_nxt;
    o_kind_r <= o_kind_nxt;
    o_hid_r  <= o_hid_nxt;
    o_btn_r  <= o_btn_nxt;
    o_dx_r   <= o_dx_nxt;
    o_dy_r   <= o_dy_nxt;
    o_w_r    <= o_w_nxt;
    o_px_r   <= o_px_nxt;
    o_py_r   <= o_py_nxt;
  end

  assign in_stall        = (state_r != iet_pkg::ST_IDLE) || ov_r;
  assign out_valid       = ov_r;
  assign out_report_kind = o_kind_r;
  assign out_hid_usage   = o_hid_r;
  assign out_button_mask = o_btn_r;
  assign out_delta_x     = o_dx_r;
  assign out_delta_y     = o_dy_r;
  assign out_wheel_delta = o_w_r;
  assign out_position_x  = o_px_r;
  assign out_position_y  = o_py_r;

endmodule

// ----- hw/rtl/iet_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iet_checker: port-level checks of the input event translator
// Watches the channels for ordering and report content rules.
// ----------------------------------------------------------------------------
module iet_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_report_kind,
  input logic [7:0]  out_hid_usage,
  input logic [4:0]  out_button_mask
);

  // A report word must stay valid and keep its kind while it is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_kind))
    else $error("report changed under stall");

  // No event is taken while a report waits.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("event taken while report pending");

  // Key reports carry a usage and no buttons.
  a_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report_kind == iet_pkg::KIND_KEY_DOWN ||
                  out_report_kind == iet_pkg::KIND_KEY_UP)
      |-> out_hid_usage != 8'd0 && out_button_mask == 5'd0)
    else $error("bad key report");

  // A report only appears after in_stall was high, as it is while an event is handled.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("report without event");

endmodule

bind input_event_translator iet_checker u_iet_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_report_kind(out_report_kind),
  .out_hid_usage  (out_hid_usage),
  .out_button_mask(out_button_mask)
);
